// ===== hw/rtl/ptcf_pkg.sv =====
package ptcf_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;

  localparam int DIFF_W   = COORD_BITS + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int DOT_W    = PROD_W + 2;
  localparam int WIDE_W   = 2 * DOT_W;
  localparam int SPLIT_W  = DOT_W / 2;
  localparam int HI_W     = DOT_W - SPLIT_W;
  localparam int THR_W    = 63;
  localparam int CMP_W    = ((WIDE_W > THR_W) ? WIDE_W : THR_W) + 1;
  localparam int WEIGHT_W = FRAC_BITS + 1;
  localparam int KIND_W   = 3;
  localparam int IN_W     = ((12 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = KIND_W + 2 * WEIGHT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam int DIV_LAT  = FRAC_BITS + 1;
  localparam int LAT      = 8 + DIV_LAT;

  // difference vectors: e12 e13 e23 d0 d2 d3
  localparam int N_DIFF = 6;
  localparam int DIFF_A [N_DIFF] = '{2, 3, 3, 0, 0, 0};
  localparam int DIFF_B [N_DIFF] = '{1, 1, 2, 1, 2, 3};
  localparam int DF_E12 = 0;
  localparam int DF_E13 = 1;

  localparam int N_DOT = 11;
  localparam int DOT_L [N_DOT] = '{0, 0, 1, 2, 0, 4, 3, 3, 5, 4, 5};
  localparam int DOT_R [N_DOT] = '{0, 1, 1, 2, 2, 2, 0, 1, 1, 0, 2};
  localparam int DT_A00   = 0;
  localparam int DT_A01   = 1;
  localparam int DT_A11   = 2;
  localparam int DT_S23   = 3;
  localparam int DT_E12E23 = 4;
  localparam int DT_D2E23 = 5;
  localparam int DT_B0    = 6;
  localparam int DT_B1    = 7;
  localparam int DT_D3E13 = 8;
  localparam int DT_D2E12 = 9;
  localparam int DT_D3E23 = 10;

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [DOT_W-1:0]  dot_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic [WEIGHT_W-1:0]      weight_t;

  typedef enum logic [KIND_W-1:0] {
    FK_VERT_A  = 3'd0,
    FK_VERT_B  = 3'd1,
    FK_VERT_C  = 3'd2,
    FK_EDGE_AB = 3'd3,
    FK_EDGE_BC = 3'd4,
    FK_EDGE_CA = 3'd5,
    FK_FACE    = 3'd6
  } feature_e;

  typedef enum logic [2:0] {
    WS_ZERO   = 3'd0,
    WS_ONE    = 3'd1,
    WS_Q0     = 3'd2,
    WS_INV_Q0 = 3'd3,
    WS_Q1     = 3'd4
  } wsel_e;

  typedef struct packed {
    feature_e kind;
    wsel_e    wb;
    wsel_e    wc;
  } tag_t;

  localparam weight_t ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

  localparam tag_t TAG_VA = '{kind: FK_VERT_A, wb: WS_ZERO, wc: WS_ZERO};
  localparam tag_t TAG_VB = '{kind: FK_VERT_B, wb: WS_ONE,  wc: WS_ZERO};
  localparam tag_t TAG_VC = '{kind: FK_VERT_C, wb: WS_ZERO, wc: WS_ONE};

  function automatic weight_t pick_weight(wsel_e s, weight_t q0, weight_t q1);
    weight_t w;
    case (s)
      WS_ZERO:   w = '0;
      WS_ONE:    w = ONE_Q;
      WS_Q0:     w = q0;
      WS_INV_Q0: w = ONE_Q - q0;
      WS_Q1:     w = q1;
      default:   w = '0;
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/point_triangle_closest_feature.sv =====
// pipeline: 8 arithmetic stages plus a 17-stage fraction divider
// that produces one quotient bit per stage
// throughput: one request per cycle; an output stall freezes the whole pipeline
// reset: valid bits clear, degenerate threshold resets to 0; payload is not reset
module point_triangle_closest_feature (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ptcf_pkg::THR_W-1:0]    cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // query_x, query_y, query_z, vert_a_x/y/z, vert_b_x/y/z, vert_c_x/y/z
  input  logic [ptcf_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // feature_kind, weight_b, weight_c, zero pad
  output logic [ptcf_pkg::OUT_W-1:0]    m_axis_tdata
);
  import ptcf_pkg::*;

  logic              adv;
  logic [LAT-1:0]    v_q;
  logic [THR_W-1:0]  thr_q;

  diff_t  diff_d [N_DIFF][3];
  diff_t  diff_q [N_DIFF][3];
  prod_t  prod_d [N_DOT][3];
  prod_t  prod_q [N_DOT][3];
  prod_t  crp_d  [6];
  prod_t  crp_q  [6];
  dot_t   dot_d  [N_DOT];
  dot_t   dot3_q [N_DOT];
  dot_t   dot4_q [N_DOT];
  dot_t   dot5_q [N_DOT];
  dot_t   dot6_q [N_DOT];
  dot_t   dot7_q [N_DOT];
  dot_t   cr_d   [3];
  dot_t   cr3_q  [3];
  wide_t  sq     [3];
  wide_t  mp     [4];
  wide_t  det6_q, t2n6_q, t3n6_q;
  wide_t  det7_q, t2n7_q, t3n7_q, t1n7_q;
  logic   degen7_q, sa00_q, sa11_q;

  tag_t   tag_d;
  tag_t   tag_q [DIV_LAT];
  dot_t   dn, dd;
  wide_t  div0_n, div0_d;
  weight_t q0, q1;
  logic   n1, n2, n3;
  logic [1:0] nneg;
  dot_t   e21e23, d31, d21, d32;

  feature_e kind_q;
  weight_t  wb_q, wc_q;

  assign adv           = !v_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = v_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= '0;
      thr_q <= '0;
    end else begin
      if (adv) begin
        v_q <= {v_q[LAT-2:0], s_axis_tvalid};
      end
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  // stage 1: edge and offset vectors
  always_comb begin
    for (int j = 0; j < N_DIFF; j++) begin
      for (int k = 0; k < 3; k++) begin
        diff_d[j][k] =
          DIFF_W'($signed(s_axis_tdata[COORD_BITS*(3*DIFF_A[j]+k) +: COORD_BITS]))
          - DIFF_W'($signed(s_axis_tdata[COORD_BITS*(3*DIFF_B[j]+k) +: COORD_BITS]));
      end
    end
  end

  // stage 2: coordinate products
  always_comb begin
    for (int i = 0; i < N_DOT; i++) begin
      for (int k = 0; k < 3; k++) begin
        prod_d[i][k] = diff_q[DOT_L[i]][k] * diff_q[DOT_R[i]][k];
      end
    end
    crp_d[0] = diff_q[DF_E12][1] * diff_q[DF_E13][2];
    crp_d[1] = diff_q[DF_E12][2] * diff_q[DF_E13][1];
    crp_d[2] = diff_q[DF_E12][2] * diff_q[DF_E13][0];
    crp_d[3] = diff_q[DF_E12][0] * diff_q[DF_E13][2];
    crp_d[4] = diff_q[DF_E12][0] * diff_q[DF_E13][1];
    crp_d[5] = diff_q[DF_E12][1] * diff_q[DF_E13][0];
  end

  // stage 3: dot products and cross product
  always_comb begin
    for (int i = 0; i < N_DOT; i++) begin
      dot_d[i] = DOT_W'(prod_q[i][0]) + DOT_W'(prod_q[i][1]) + DOT_W'(prod_q[i][2]);
    end
    for (int j = 0; j < 3; j++) begin
      cr_d[j] = DOT_W'(crp_q[2*j]) - DOT_W'(crp_q[2*j+1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      diff_q <= diff_d;
      prod_q <= prod_d;
      crp_q  <= crp_d;
      dot3_q <= dot_d;
      cr3_q  <= cr_d;
      dot4_q <= dot3_q;
      dot5_q <= dot4_q;
      dot6_q <= dot5_q;
      dot7_q <= dot6_q;
      det6_q <= sq[0] + sq[1] + sq[2];
      t2n6_q <= mp[0] - mp[1];
      t3n6_q <= mp[2] - mp[3];
      det7_q <= det6_q;
      t2n7_q <= t2n6_q;
      t3n7_q <= t3n6_q;
      t1n7_q <= det6_q - t2n6_q - t3n6_q;
      degen7_q <= CMP_W'($unsigned(det6_q)) <= CMP_W'(thr_q);
      sa00_q <= CMP_W'($unsigned(dot6_q[DT_A00])) <= CMP_W'(thr_q);
      sa11_q <= CMP_W'($unsigned(dot6_q[DT_A11])) <= CMP_W'(thr_q);
    end
  end

  // stages 4-5: wide products; squared cross norm equals the gram determinant
  for (genvar j = 0; j < 3; j++) begin : g_crsq
    ptcf_wide_mul u_sq (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (cr3_q[j]),
      .b_i   (cr3_q[j]),
      .p_o   (sq[j])
    );
  end

  ptcf_wide_mul u_m0 (.clk_i(clk_i), .en_i(adv), .a_i(dot3_q[DT_B0]),
                      .b_i(dot3_q[DT_A11]), .p_o(mp[0]));
  ptcf_wide_mul u_m1 (.clk_i(clk_i), .en_i(adv), .a_i(dot3_q[DT_B1]),
                      .b_i(dot3_q[DT_A01]), .p_o(mp[1]));
  ptcf_wide_mul u_m2 (.clk_i(clk_i), .en_i(adv), .a_i(dot3_q[DT_A00]),
                      .b_i(dot3_q[DT_B1]), .p_o(mp[2]));
  ptcf_wide_mul u_m3 (.clk_i(clk_i), .en_i(adv), .a_i(dot3_q[DT_B0]),
                      .b_i(dot3_q[DT_A01]), .p_o(mp[3]));

  // stage 8: feature decision
  assign n1     = t1n7_q[WIDE_W-1];
  assign n2     = t2n7_q[WIDE_W-1];
  assign n3     = t3n7_q[WIDE_W-1];
  assign nneg   = {1'b0, n1} + {1'b0, n2} + {1'b0, n3};
  assign e21e23 = -dot7_q[DT_E12E23];
  assign d31    = -dot7_q[DT_D3E13];
  assign d21    = -dot7_q[DT_D2E12];
  assign d32    = -dot7_q[DT_D3E23];

  always_comb begin
    tag_d = TAG_VA;
    dn    = '0;
    dd    = '0;
    if (degen7_q) begin
      if (sa00_q && sa11_q) begin
        tag_d = TAG_VA;
      end else if (dot7_q[DT_A01] <= 0) begin
        if (dot7_q[DT_D2E23] >= dot7_q[DT_S23]) begin
          tag_d = TAG_VC;
        end else if (dot7_q[DT_D2E23] <= 0) begin
          tag_d = TAG_VB;
        end else begin
          tag_d = '{kind: FK_EDGE_BC, wb: WS_INV_Q0, wc: WS_Q0};
          dn = dot7_q[DT_D2E23];
          dd = dot7_q[DT_S23];
        end
      end else if (e21e23 <= 0) begin
        if (dot7_q[DT_B1] >= dot7_q[DT_A11]) begin
          tag_d = TAG_VC;
        end else if (dot7_q[DT_B1] <= 0) begin
          tag_d = TAG_VA;
        end else begin
          tag_d = '{kind: FK_EDGE_CA, wb: WS_ZERO, wc: WS_Q0};
          dn = dot7_q[DT_B1];
          dd = dot7_q[DT_A11];
        end
      end else begin
        if (dot7_q[DT_B0] >= dot7_q[DT_A00]) begin
          tag_d = TAG_VB;
        end else if (dot7_q[DT_B0] <= 0) begin
          tag_d = TAG_VA;
        end else begin
          tag_d = '{kind: FK_EDGE_AB, wb: WS_Q0, wc: WS_ZERO};
          dn = dot7_q[DT_B0];
          dd = dot7_q[DT_A00];
        end
      end
    end else if (nneg == 2'd0) begin
      tag_d = '{kind: FK_FACE, wb: WS_Q0, wc: WS_Q1};
    end else if (nneg == 2'd1) begin
      if (n1) begin
        if (dot7_q[DT_D2E23] < 0) begin
          tag_d = TAG_VB;
        end else if (dot7_q[DT_D2E23] > dot7_q[DT_S23]) begin
          tag_d = TAG_VC;
        end else begin
          tag_d = '{kind: FK_EDGE_BC, wb: WS_INV_Q0, wc: WS_Q0};
          dn = dot7_q[DT_D2E23];
          dd = dot7_q[DT_S23];
        end
      end else if (n2) begin
        if (d31 < 0) begin
          tag_d = TAG_VC;
        end else if (d31 > dot7_q[DT_A11]) begin
          tag_d = TAG_VA;
        end else begin
          tag_d = '{kind: FK_EDGE_CA, wb: WS_ZERO, wc: WS_INV_Q0};
          dn = d31;
          dd = dot7_q[DT_A11];
        end
      end else begin
        if (dot7_q[DT_B0] < 0) begin
          tag_d = TAG_VA;
        end else if (dot7_q[DT_B0] > dot7_q[DT_A00]) begin
          tag_d = TAG_VB;
        end else begin
          tag_d = '{kind: FK_EDGE_AB, wb: WS_Q0, wc: WS_ZERO};
          dn = dot7_q[DT_B0];
          dd = dot7_q[DT_A00];
        end
      end
    end else if (!n1) begin
      if (dot7_q[DT_B0] > 0 && dot7_q[DT_B1] <= 0) begin
        if (dot7_q[DT_B0] > dot7_q[DT_A00]) begin
          tag_d = TAG_VB;
        end else begin
          tag_d = '{kind: FK_EDGE_AB, wb: WS_Q0, wc: WS_ZERO};
          dn = dot7_q[DT_B0];
          dd = dot7_q[DT_A00];
        end
      end else if (dot7_q[DT_B1] > 0 && dot7_q[DT_B0] <= 0) begin
        if (dot7_q[DT_B1] > dot7_q[DT_A11]) begin
          tag_d = TAG_VC;
        end else begin
          tag_d = '{kind: FK_EDGE_CA, wb: WS_ZERO, wc: WS_Q0};
          dn = dot7_q[DT_B1];
          dd = dot7_q[DT_A11];
        end
      end else begin
        tag_d = TAG_VA;
      end
    end else if (!n2) begin
      if (dot7_q[DT_D2E23] > 0 && d21 <= 0) begin
        if (dot7_q[DT_D2E23] > dot7_q[DT_S23]) begin
          tag_d = TAG_VC;
        end else begin
          tag_d = '{kind: FK_EDGE_BC, wb: WS_INV_Q0, wc: WS_Q0};
          dn = dot7_q[DT_D2E23];
          dd = dot7_q[DT_S23];
        end
      end else if (d21 > 0 && dot7_q[DT_D2E23] <= 0) begin
        if (d21 > dot7_q[DT_A00]) begin
          tag_d = TAG_VA;
        end else begin
          tag_d = '{kind: FK_EDGE_AB, wb: WS_INV_Q0, wc: WS_ZERO};
          dn = d21;
          dd = dot7_q[DT_A00];
        end
      end else begin
        tag_d = TAG_VB;
      end
    end else begin
      if (d31 > 0 && d32 <= 0) begin
        if (d31 > dot7_q[DT_A11]) begin
          tag_d = TAG_VA;
        end else begin
          tag_d = '{kind: FK_EDGE_CA, wb: WS_ZERO, wc: WS_INV_Q0};
          dn = d31;
          dd = dot7_q[DT_A11];
        end
      end else if (d32 > 0 && d31 <= 0) begin
        if (d32 > dot7_q[DT_S23]) begin
          tag_d = TAG_VB;
        end else begin
          tag_d = '{kind: FK_EDGE_BC, wb: WS_Q0, wc: WS_INV_Q0};
          dn = d32;
          dd = dot7_q[DT_S23];
        end
      end else begin
        tag_d = TAG_VC;
      end
    end
  end

  assign div0_n = (tag_d.kind == FK_FACE) ? t2n7_q : WIDE_W'(dn);
  assign div0_d = (tag_d.kind == FK_FACE) ? det7_q : WIDE_W'(dd);

  ptcf_frac_div u_div0 (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (div0_n),
    .den_i (div0_d),
    .q_o   (q0)
  );

  ptcf_frac_div u_div1 (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (t3n7_q),
    .den_i (det7_q),
    .q_o   (q1)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tag_q[0] <= tag_d;
      for (int k = 1; k < DIV_LAT; k++) begin
        tag_q[k] <= tag_q[k-1];
      end
      kind_q <= tag_q[DIV_LAT-1].kind;
      wb_q   <= pick_weight(tag_q[DIV_LAT-1].wb, q0, q1);
      wc_q   <= pick_weight(tag_q[DIV_LAT-1].wc, q0, q1);
    end
  end

  assign m_axis_tdata = OUT_W'({wc_q, wb_q, kind_q});

endmodule

// ===== hw/rtl/ptcf_wide_mul.sv =====
module ptcf_wide_mul (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  ptcf_pkg::dot_t         a_i,
  input  ptcf_pkg::dot_t         b_i,
  output ptcf_pkg::wide_t        p_o
);
  import ptcf_pkg::*;

  logic signed [2*HI_W-1:0]       hh_q;
  logic signed [HI_W+SPLIT_W:0]   hl_q;
  logic signed [HI_W+SPLIT_W:0]   lh_q;
  logic        [2*SPLIT_W-1:0]    ll_q;
  wide_t                          p_q;

  // split product: signed high halves, unsigned low halves
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q <= $signed(a_i[DOT_W-1:SPLIT_W]) * $signed(b_i[DOT_W-1:SPLIT_W]);
      hl_q <= $signed(a_i[DOT_W-1:SPLIT_W]) * $signed({1'b0, b_i[SPLIT_W-1:0]});
      lh_q <= $signed({1'b0, a_i[SPLIT_W-1:0]}) * $signed(b_i[DOT_W-1:SPLIT_W]);
      ll_q <= a_i[SPLIT_W-1:0] * b_i[SPLIT_W-1:0];
      p_q  <= (WIDE_W'(hh_q) <<< (2 * SPLIT_W))
            + ((WIDE_W'(hl_q) + WIDE_W'(lh_q)) <<< SPLIT_W)
            + $signed(WIDE_W'({1'b0, ll_q}));
    end
  end

  assign p_o = p_q;

endmodule

// ===== hw/rtl/ptcf_frac_div.sv =====
module ptcf_frac_div (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  ptcf_pkg::wide_t        num_i,
  input  ptcf_pkg::wide_t        den_i,
  output ptcf_pkg::weight_t      q_o
);
  import ptcf_pkg::*;

  logic [WIDE_W-1:0]    r_q   [FRAC_BITS+1];
  logic [WIDE_W-1:0]    den_q [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] q_q   [FRAC_BITS+1];
  logic [FRAC_BITS:0]   fix_q;
  logic [FRAC_BITS:0]   fixv_q;

  logic [WIDE_W:0]      sh [FRAC_BITS];
  logic [WIDE_W-1:0]    rn [FRAC_BITS];
  logic [FRAC_BITS-1:0] ge;
  logic                 den_pos;
  logic                 num_pos;
  logic                 num_ge;

  assign den_pos = den_i > 0;
  assign num_pos = num_i > 0;
  assign num_ge  = num_i >= den_i;

  // one quotient bit per stage, restoring
  always_comb begin
    for (int k = 0; k < FRAC_BITS; k++) begin
      sh[k] = {r_q[k], 1'b0};
      ge[k] = sh[k] >= {1'b0, den_q[k]};
      rn[k] = ge[k] ? WIDE_W'(sh[k] - {1'b0, den_q[k]}) : sh[k][WIDE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]    <= num_i;
      den_q[0]  <= den_i;
      q_q[0]    <= '0;
      fix_q[0]  <= !den_pos || !num_pos || num_ge;
      fixv_q[0] <= !den_pos || num_pos;
      for (int k = 0; k < FRAC_BITS; k++) begin
        r_q[k+1]    <= rn[k];
        den_q[k+1]  <= den_q[k];
        q_q[k+1]    <= {q_q[k][FRAC_BITS-2:0], ge[k]};
        fix_q[k+1]  <= fix_q[k];
        fixv_q[k+1] <= fixv_q[k];
      end
    end
  end

  assign q_o = fix_q[FRAC_BITS] ? (fixv_q[FRAC_BITS] ? ONE_Q : '0)
                                : {1'b0, q_q[FRAC_BITS]};

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import ptcf_pkg::*;

  typedef logic signed [159:0] big_t;
  typedef longint vec3_t [3];

  typedef struct packed {
    feature_e kind;
    weight_t  wb;
    weight_t  wc;
  } feature_res_t;

  localparam int ITEMS_PER_PHASE = 500;
  localparam int CYCLE_LIMIT     = 2000000;
  localparam int DRAIN_CYCLES    = LAT + 10;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [THR_W-1:0]    cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OUT_W-1:0]    m_axis_tdata;

  logic [THR_W-1:0]    threshold;
  feature_res_t        expected_q [$];
  int                  n_mismatch;
  int                  send_idle_pct;
  int                  recv_stall_pct;
  int                  cycles;

  point_triangle_closest_feature i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------- predictor ----------------

  function automatic vec3_t vsub(vec3_t a, vec3_t b);
    vec3_t r;
    for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
    return r;
  endfunction

  function automatic longint vdot(vec3_t a, vec3_t b);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  function automatic big_t bmul(longint a, longint b);
    return big_t'(a) * big_t'(b);
  endfunction

  // floor(num * 2^FRAC_BITS / den), clamped to 0..1
  function automatic weight_t frac_of(big_t num, big_t den);
    big_t q;
    if (den <= 0) return ONE_Q;
    if (num <= 0) return '0;
    if (num >= den) return ONE_Q;
    q = (num <<< FRAC_BITS) / den;
    return q[WEIGHT_W-1:0];
  endfunction

  function automatic weight_t frac_s(longint num, longint den);
    return frac_of(big_t'(num), big_t'(den));
  endfunction

  function automatic feature_res_t mk(feature_e k, weight_t b, weight_t c);
    feature_res_t r;
    r.kind = k;
    r.wb   = b;
    r.wc   = c;
    return r;
  endfunction

  function automatic feature_res_t closest_feature(logic [IN_W-1:0] d, logic [THR_W-1:0] thr);
    vec3_t p0, p1, p2, p3, e12, e13, e23, e21, e31, e32, d0, d2, d3, cr;
    longint a00, a01, a11, b0, b1, dt, sq, x23, x21, x31, x32;
    big_t cn, thrb, det, t1n, t2n, t3n;
    weight_t w;
    int nneg;
    for (int i = 0; i < 3; i++) begin
      p0[i] = longint'($signed(d[i*COORD_BITS +: COORD_BITS]));
      p1[i] = longint'($signed(d[(3+i)*COORD_BITS +: COORD_BITS]));
      p2[i] = longint'($signed(d[(6+i)*COORD_BITS +: COORD_BITS]));
      p3[i] = longint'($signed(d[(9+i)*COORD_BITS +: COORD_BITS]));
    end
    e12 = vsub(p2, p1); e13 = vsub(p3, p1); e23 = vsub(p3, p2);
    e21 = vsub(p1, p2); e31 = vsub(p1, p3); e32 = vsub(p2, p3);
    d0 = vsub(p0, p1); d2 = vsub(p0, p2); d3 = vsub(p0, p3);
    a00 = vdot(e12, e12); a01 = vdot(e12, e13); a11 = vdot(e13, e13);
    cr[0] = e12[1] * e13[2] - e12[2] * e13[1];
    cr[1] = e12[2] * e13[0] - e12[0] * e13[2];
    cr[2] = e12[0] * e13[1] - e12[1] * e13[0];
    cn = bmul(cr[0], cr[0]) + bmul(cr[1], cr[1]) + bmul(cr[2], cr[2]);
    thrb = big_t'({1'b0, thr});

    if (cn <= thrb) begin
      if (big_t'(a00) <= thrb && big_t'(a11) <= thrb) return mk(FK_VERT_A, '0, '0);
      if (a01 <= 0) begin
        dt = vdot(d2, e23); sq = vdot(e23, e23);
        if (dt >= sq) return mk(FK_VERT_C, '0, ONE_Q);
        if (dt <= 0) return mk(FK_VERT_B, ONE_Q, '0);
        w = frac_s(dt, sq);
        return mk(FK_EDGE_BC, ONE_Q - w, w);
      end
      if (vdot(e21, e23) <= 0) begin
        dt = vdot(d0, e13);
        if (dt >= a11) return mk(FK_VERT_C, '0, ONE_Q);
        if (dt <= 0) return mk(FK_VERT_A, '0, '0);
        return mk(FK_EDGE_CA, '0, frac_s(dt, a11));
      end
      dt = vdot(d0, e12);
      if (dt >= a00) return mk(FK_VERT_B, ONE_Q, '0);
      if (dt <= 0) return mk(FK_VERT_A, '0, '0);
      return mk(FK_EDGE_AB, frac_s(dt, a00), '0);
    end

    b0 = vdot(d0, e12); b1 = vdot(d0, e13);
    det = bmul(a00, a11) - bmul(a01, a01);
    t2n = bmul(b0, a11) - bmul(b1, a01);
    t3n = bmul(a00, b1) - bmul(b0, a01);
    t1n = det - t2n - t3n;
    nneg = int'(t1n < 0) + int'(t2n < 0) + int'(t3n < 0);

    if (nneg == 0) return mk(FK_FACE, frac_of(t2n, det), frac_of(t3n, det));

    if (nneg == 1) begin
      if (t1n < 0) begin
        dt = vdot(e23, d2); sq = vdot(e23, e23);
        if (dt < 0) return mk(FK_VERT_B, ONE_Q, '0);
        if (dt > sq) return mk(FK_VERT_C, '0, ONE_Q);
        w = frac_s(dt, sq);
        return mk(FK_EDGE_BC, ONE_Q - w, w);
      end
      if (t2n < 0) begin
        dt = vdot(e31, d3); sq = vdot(e31, e31);
        if (dt < 0) return mk(FK_VERT_C, '0, ONE_Q);
        if (dt > sq) return mk(FK_VERT_A, '0, '0);
        return mk(FK_EDGE_CA, '0, ONE_Q - frac_s(dt, sq));
      end
      if (b0 < 0) return mk(FK_VERT_A, '0, '0);
      if (b0 > a00) return mk(FK_VERT_B, ONE_Q, '0);
      return mk(FK_EDGE_AB, frac_s(b0, a00), '0);
    end

    if (t1n >= 0) begin
      if (b0 > 0 && b1 <= 0) begin
        if (b0 > a00) return mk(FK_VERT_B, ONE_Q, '0);
        return mk(FK_EDGE_AB, frac_s(b0, a00), '0);
      end
      if (b1 > 0 && b0 <= 0) begin
        if (b1 > a11) return mk(FK_VERT_C, '0, ONE_Q);
        return mk(FK_EDGE_CA, '0, frac_s(b1, a11));
      end
      return mk(FK_VERT_A, '0, '0);
    end
    if (t2n >= 0) begin
      x23 = vdot(e23, d2); x21 = vdot(e21, d2);
      if (x23 > 0 && x21 <= 0) begin
        sq = vdot(e23, e23);
        if (x23 > sq) return mk(FK_VERT_C, '0, ONE_Q);
        w = frac_s(x23, sq);
        return mk(FK_EDGE_BC, ONE_Q - w, w);
      end
      if (x21 > 0 && x23 <= 0) begin
        sq = vdot(e21, e21);
        if (x21 > sq) return mk(FK_VERT_A, '0, '0);
        return mk(FK_EDGE_AB, ONE_Q - frac_s(x21, sq), '0);
      end
      return mk(FK_VERT_B, ONE_Q, '0);
    end
    x31 = vdot(e31, d3); x32 = vdot(e32, d3);
    if (x31 > 0 && x32 <= 0) begin
      sq = vdot(e31, e31);
      if (x31 > sq) return mk(FK_VERT_A, '0, '0);
      return mk(FK_EDGE_CA, '0, ONE_Q - frac_s(x31, sq));
    end
    if (x32 > 0 && x31 <= 0) begin
      sq = vdot(e32, e32);
      if (x32 > sq) return mk(FK_VERT_B, ONE_Q, '0);
      w = frac_s(x32, sq);
      return mk(FK_EDGE_BC, w, ONE_Q - w);
    end
    return mk(FK_VERT_C, '0, ONE_Q);
  endfunction

  // ---------------- result check ----------------

  always @(posedge clk_i) begin
    feature_res_t got, exp_res;
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = feature_e'(m_axis_tdata[2:0]);
        got.wb   = m_axis_tdata[3 +: WEIGHT_W];
        got.wc   = m_axis_tdata[3 + WEIGHT_W +: WEIGHT_W];
        if (expected_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("result with none expected: %p", got);
        end else begin
          exp_res = expected_q.pop_front();
          if (got !== exp_res) begin
            n_mismatch++;
            if (n_mismatch <= 10) $display("expected %p, got %p", exp_res, got);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------- stimulus ----------------

  task automatic send_query(logic [IN_W-1:0] d);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q.push_back(closest_feature(d, threshold));
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_threshold(logic [THR_W-1:0] v);
    wait_drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    threshold    = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [IN_W-1:0] pack_pts(int c [12]);
    logic [IN_W-1:0] d;
    d = '0;
    for (int i = 0; i < 12; i++) d[i*COORD_BITS +: COORD_BITS] = COORD_BITS'(c[i]);
    return d;
  endfunction

  function automatic int rnd_span(int base, int span);
    return base + $urandom_range(2 * span) - span;
  endfunction

  function automatic logic [IN_W-1:0] random_query();
    int c [12];
    int dir [3];
    int a, b, span, base;
    case ($urandom_range(5))
      0: for (int i = 0; i < 12; i++) c[i] = $urandom_range(65535) - 32768;
      1, 2: begin
        span = ($urandom_range(1)) ? 8 : 1000;
        base = $urandom_range(20000) - 10000;
        for (int i = 0; i < 12; i++) c[i] = rnd_span(base, span);
      end
      3: begin
        // collinear triangle, point nearby
        for (int k = 0; k < 3; k++) begin
          dir[k] = $urandom_range(20) - 10;
          c[3+k] = $urandom_range(2000) - 1000;
        end
        a = $urandom_range(60) - 30;
        b = $urandom_range(60) - 30;
        for (int k = 0; k < 3; k++) begin
          c[6+k] = c[3+k] + a * dir[k];
          c[9+k] = c[3+k] + b * dir[k];
          c[k]   = rnd_span(c[3+k], 400);
        end
      end
      4: begin
        // near-coincident vertices
        for (int k = 0; k < 3; k++) begin
          c[3+k] = $urandom_range(60000) - 30000;
          c[6+k] = rnd_span(c[3+k], 1);
          c[9+k] = rnd_span(c[3+k], 1);
          c[k]   = rnd_span(c[3+k], 50);
        end
      end
      default: begin
        for (int k = 0; k < 3; k++) begin
          c[3+k] = $urandom_range(65535) - 32768;
          c[6+k] = $urandom_range(65535) - 32768;
          c[9+k] = $urandom_range(65535) - 32768;
          c[k]   = $urandom_range(65535) - 32768;
        end
      end
    endcase
    return pack_pts(c);
  endfunction

  task automatic test_directed();
    int t [12];
    // extremes
    t = '{default: -32768};  send_query(pack_pts(t));
    t = '{default: 32767};   send_query(pack_pts(t));
    t = '{32767, -32768, 32767, -32768, -32768, -32768, 32767, -32768, -32768,
          -32768, 32767, 32767};
    send_query(pack_pts(t));
    t = '{-32768, 32767, -32768, 32767, 32767, 32767, -32768, 32767, 32767,
          32767, -32768, -32768};
    send_query(pack_pts(t));
    // triangle (0,0,0) (100,0,0) (0,100,0): face, each vertex, each edge
    t = '{20, 30, 50, 0, 0, 0, 100, 0, 0, 0, 100, 0};   send_query(pack_pts(t));
    t = '{-10, -20, 5, 0, 0, 0, 100, 0, 0, 0, 100, 0};  send_query(pack_pts(t));
    t = '{150, -5, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0};   send_query(pack_pts(t));
    t = '{-5, 150, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0};   send_query(pack_pts(t));
    t = '{40, -30, 9, 0, 0, 0, 100, 0, 0, 0, 100, 0};   send_query(pack_pts(t));
    t = '{80, 80, -9, 0, 0, 0, 100, 0, 0, 0, 100, 0};   send_query(pack_pts(t));
    t = '{-30, 40, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0};   send_query(pack_pts(t));
    t = '{0, 0, 7, 0, 0, 0, 100, 0, 0, 0, 100, 0};      send_query(pack_pts(t));
    // obtuse triangle, two negative weights regions
    t = '{300, -200, 0, 0, 0, 0, 100, 0, 0, -50, 10, 0}; send_query(pack_pts(t));
    t = '{-300, 50, 0, 0, 0, 0, 100, 0, 0, -50, 10, 0};  send_query(pack_pts(t));
    // degenerate: coincident, zero-length edge, collinear variants
    t = '{5, 5, 5, 1, 1, 1, 1, 1, 1, 1, 1, 1};          send_query(pack_pts(t));
    t = '{5, 0, 0, 0, 0, 0, 0, 0, 0, 10, 0, 0};         send_query(pack_pts(t));
    t = '{3, 2, 0, 0, 0, 0, 10, 0, 0, -10, 0, 0};       send_query(pack_pts(t));
    t = '{7, 2, 0, 0, 0, 0, 10, 0, 0, 5, 0, 0};         send_query(pack_pts(t));
    t = '{4, 2, 0, 0, 0, 0, 5, 0, 0, 10, 0, 0};         send_query(pack_pts(t));
    t = '{-4, 2, 0, 0, 0, 0, 5, 0, 0, 10, 0, 0};        send_query(pack_pts(t));
    t = '{40, 2, 0, 0, 0, 0, 5, 0, 0, 10, 0, 0};        send_query(pack_pts(t));
  endtask

  task automatic test_random(int idle, int stall, logic [THR_W-1:0] thr);
    set_threshold(thr);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      send_query(random_query());
      if (n == ITEMS_PER_PHASE / 2 && idle == 0) begin
        // hold off until the pipeline has emptied
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (expected_q.size() != 0) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    threshold      = '0;
    n_mismatch     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cycles         = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    set_threshold(63'd200);
    test_directed();
    set_threshold({THR_W{1'b1}});
    test_directed();

    test_random(0, 0, 63'd0);
    test_random(50, 0, 63'd1000);
    test_random(0, 50, {THR_W{1'b1}});
    test_random(8, 8, {23'd0, $urandom(), 8'($urandom_range(255))});
    wait_drain();

    if (n_mismatch == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
